// ----- hw/rtl/mhpq_pkg.sv -----
// Package for the max-heap priority queue core.
// Holds shared widths, opcodes, status codes and the controller/datapath structs.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;

  localparam logic [ValueW-1:0] INT_MIN_BITS = 32'h8000_0000;

  // Datapath operation selected by the controller in each state.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,      // latch input item, check bounds
    DP_UP_RD,      // read parent of pos
    DP_UP_CMP,     // move parent down into pos when the new value is larger
    DP_UP_WR,      // write new value at pos, count up
    DP_RM_ROOT,    // read root, count down
    DP_RM_LAST,    // capture root, read last entry
    DP_RM_LOAD,    // last entry becomes the value to sink
    DP_DN_RDL,     // read left child
    DP_DN_RDR,     // capture left child, read right child
    DP_DN_CMP,     // move the larger child up when it beats the value
    DP_DN_WR,      // write sinking value at pos
    DP_FINISH,     // read root for the result
    DP_RESULT      // capture result
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic refused;
    logic at_root;    // pos is the root
    logic up_move;    // sift-up continues
    logic has_left;   // pos has a left child
    logic dn_move;    // sift-down continues
  } dp_status_t;

endpackage

// ----- hw/rtl/max_heap_priority_queue_core.sv -----
// Binary max-heap priority queue of signed 32-bit values held in a single-port RAM.
// Input stream: in_tuser is the opcode (0 insert, 1 remove maximum), in_tdata the
// value to insert, ignored for a remove. Every input transfer yields exactly one
// output transfer with the removed value, the maximum afterwards (most negative
// value when empty), the count, an empty flag and a status code.
// One item is processed at a time; in_tready is high only while the block is idle.
// An insert reads the parent and moves it down at each level that the value rises;
// a remove reads both children and moves the larger one up at each level that the
// value sinks; a refused item goes straight to the result. The cost comes from the
// single RAM port: each level needs its own reads and a write. After each output
// transfer the block returns to idle before it takes the next input transfer.
// The result holds in out_tdata while out_tready is low, and no input is taken then.
// Reset empties the queue (count cleared) and returns to idle; RAM is not cleared.
// Insert into a full queue and remove from an empty one report a status code
// and leave the queue unchanged.
// Depends on mhpq_pkg, mhpq_controller and mhpq_datapath.
module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefCapacity
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] value
  input  logic         in_tuser,   // [0] opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata   // [31:0] removed_value, [63:32] top_value,
                                   // [70:64] count, [71] is_empty, [73:72] status
);

  mhpq_pkg::ctl_cmd_t   ctl;
  mhpq_pkg::dp_status_t sts;
  logic [31:0] r_rem, r_top;
  logic [6:0]  r_cnt;
  logic        r_emp;
  logic [1:0]  r_st;

  mhpq_controller u_ctl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .sts(sts), .ctl(ctl)
  );

  mhpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_opcode(in_tuser), .in_value(in_tdata), .sts(sts),
    .res_removed(r_rem), .res_top(r_top), .res_count(r_cnt),
    .res_empty(r_emp), .res_status(r_st)
  );

  assign out_tdata = {6'd0, r_st, r_emp, r_cnt, r_top, r_rem};

endmodule

// ----- hw/rtl/mhpq_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/mhpq_datapath.sv -----
// Datapath for the max-heap queue: heap RAM, positions, count and result registers.
// Depends on mhpq_pkg and mhpq_ram.
module mhpq_datapath #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefCapacity
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mhpq_pkg::ctl_cmd_t          ctl,
  input  logic                        in_opcode,
  input  logic [mhpq_pkg::ValueW-1:0] in_value,
  output mhpq_pkg::dp_status_t        sts,
  output logic [mhpq_pkg::ValueW-1:0] res_removed,
  output logic [mhpq_pkg::ValueW-1:0] res_top,
  output logic [mhpq_pkg::CountW-1:0] res_count,
  output logic                        res_empty,
  output logic [1:0]                  res_status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = mhpq_pkg::ValueW;

  logic [CW-1:0] count_r;
  logic          op_r;
  logic          refused_r;
  logic [1:0]    status_r;
  logic [VW-1:0] val_r;      // value being sifted
  logic [VW-1:0] left_r;     // left child value during sift-down
  logic [VW-1:0] removed_r;
  logic [AW-1:0] pos_r;      // hole position

  logic [VW-1:0]               res_removed_r, res_top_r;
  logic [mhpq_pkg::CountW-1:0] res_count_r;
  logic                        res_empty_r;
  logic [1:0]                  res_status_r;

  logic          we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;

  logic [CW:0]   left_w, right_w;
  logic [AW-1:0] parent_w;
  logic          has_left, has_right;
  logic          up_move, pick_right, pick_left;

  function automatic logic gt(input logic [VW-1:0] a, input logic [VW-1:0] b);
    gt = $signed(a) > $signed(b);
  endfunction

  mhpq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Tree neighbors of the hole and the comparisons on the data just read.
  assign left_w     = (CW+1)'({pos_r, 1'b1});
  assign right_w    = left_w + (CW+1)'(1);
  assign parent_w   = (pos_r - AW'(1)) >> 1;
  assign has_left   = left_w < {1'b0, count_r};
  assign has_right  = right_w < {1'b0, count_r};
  assign up_move    = gt(val_r, rdata);
  assign pick_right = has_right && gt(rdata, left_r) && gt(rdata, val_r);
  assign pick_left  = !pick_right && gt(left_r, val_r);

  // RAM port steering per command.
  always_comb begin
    we = 1'b0;
    addr = pos_r;
    wdata = val_r;
    unique case (ctl.cmd)
      mhpq_pkg::DP_UP_RD:   addr = parent_w;
      mhpq_pkg::DP_UP_CMP: begin
        we = up_move; wdata = rdata;
      end
      mhpq_pkg::DP_UP_WR:   we = 1'b1;
      mhpq_pkg::DP_RM_ROOT: addr = '0;
      mhpq_pkg::DP_RM_LAST: addr = AW'(count_r);
      mhpq_pkg::DP_DN_RDL:  addr = AW'(left_w);
      mhpq_pkg::DP_DN_RDR:  addr = AW'(right_w);
      mhpq_pkg::DP_DN_CMP: begin
        we = pick_right | pick_left;
        wdata = pick_right ? rdata : left_r;
      end
      mhpq_pkg::DP_DN_WR:   we = 1'b1;
      mhpq_pkg::DP_FINISH:  addr = '0;
      default: ;
    endcase
  end

  // State updates per command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      refused_r <= 1'b0;
      op_r <= 1'b0;
      status_r <= mhpq_pkg::ST_OK;
      removed_r <= '0;
      res_removed_r <= '0;
      res_top_r <= mhpq_pkg::INT_MIN_BITS;
      res_count_r <= '0;
      res_empty_r <= 1'b1;
      res_status_r <= mhpq_pkg::ST_OK;
    end else begin
      case (ctl.cmd)
        mhpq_pkg::DP_START: begin
          op_r <= in_opcode;
          val_r <= in_value;
          removed_r <= '0;
          pos_r <= AW'(count_r);
          if (in_opcode == mhpq_pkg::OP_INSERT) begin
            refused_r <= (count_r == CW'(CAPACITY));
            status_r <= (count_r == CW'(CAPACITY)) ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
          end else begin
            refused_r <= (count_r == '0);
            status_r <= (count_r == '0) ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
          end
        end
        mhpq_pkg::DP_UP_CMP: begin
          if (up_move) pos_r <= parent_w;
        end
        mhpq_pkg::DP_UP_WR: count_r <= count_r + CW'(1);
        mhpq_pkg::DP_RM_ROOT: count_r <= count_r - CW'(1);
        mhpq_pkg::DP_RM_LAST: begin
          removed_r <= rdata;  // root read issued in the previous cycle
          pos_r <= '0;
        end
        mhpq_pkg::DP_RM_LOAD: val_r <= rdata;
        mhpq_pkg::DP_DN_RDR: left_r <= rdata;
        mhpq_pkg::DP_DN_CMP: begin
          // rdata is the right child when present.
          if (pick_right) begin
            pos_r <= AW'(right_w);
          end else if (pick_left) begin
            pos_r <= AW'(left_w);
          end
        end
        mhpq_pkg::DP_RESULT: begin
          res_top_r <= (count_r == '0) ? mhpq_pkg::INT_MIN_BITS : rdata;
          res_count_r <= mhpq_pkg::CountW'(count_r);
          res_empty_r <= (count_r == '0);
          res_removed_r <= removed_r;
          res_status_r <= status_r;
        end
        default: ;
      endcase
    end
  end

  assign res_removed = res_removed_r;
  assign res_top     = res_top_r;
  assign res_count   = res_count_r;
  assign res_empty   = res_empty_r;
  assign res_status  = res_status_r;

  assign sts.is_remove = op_r;
  assign sts.refused   = refused_r;
  assign sts.at_root   = (pos_r == '0);
  assign sts.up_move   = up_move;
  assign sts.has_left  = has_left;
  assign sts.dn_move   = pick_right | pick_left;

endmodule

// ----- hw/rtl/mhpq_controller.sv -----
// Controller state machine for the max-heap queue.
// Depends on mhpq_pkg; drives mhpq_datapath through a command struct.
module mhpq_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  mhpq_pkg::dp_status_t sts,
  output mhpq_pkg::ctl_cmd_t   ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_UP_RD, S_UP_CMP, S_UP_WR, S_RM_ROOT, S_RM_LAST, S_RM_LOAD,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_WR, S_FIN, S_RES, S_OUT
  } state_t;

  state_t state_r;

  // Command decode from state.
  always_comb begin
    ctl.cmd = mhpq_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE:    ctl.cmd = (in_tvalid) ? mhpq_pkg::DP_START : mhpq_pkg::DP_NOP;
      S_UP_RD:   ctl.cmd = mhpq_pkg::DP_UP_RD;
      S_UP_CMP:  ctl.cmd = mhpq_pkg::DP_UP_CMP;
      S_UP_WR:   ctl.cmd = mhpq_pkg::DP_UP_WR;
      S_RM_ROOT: ctl.cmd = mhpq_pkg::DP_RM_ROOT;
      S_RM_LAST: ctl.cmd = mhpq_pkg::DP_RM_LAST;
      S_RM_LOAD: ctl.cmd = mhpq_pkg::DP_RM_LOAD;
      S_DN_RDL:  ctl.cmd = mhpq_pkg::DP_DN_RDL;
      S_DN_RDR:  ctl.cmd = mhpq_pkg::DP_DN_RDR;
      S_DN_CMP:  ctl.cmd = mhpq_pkg::DP_DN_CMP;
      S_DN_WR:   ctl.cmd = mhpq_pkg::DP_DN_WR;
      S_FIN:     ctl.cmd = mhpq_pkg::DP_FINISH;
      S_RES:     ctl.cmd = mhpq_pkg::DP_RESULT;
      default:   ctl.cmd = mhpq_pkg::DP_NOP;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:    if (in_tvalid) state_r <= S_CHECK;
        S_CHECK:   state_r <= sts.refused ? S_FIN :
                              (sts.is_remove ? S_RM_ROOT : S_UP_RD);
        S_UP_RD:   state_r <= sts.at_root ? S_UP_WR : S_UP_CMP;
        S_UP_CMP:  state_r <= sts.up_move ? S_UP_RD : S_UP_WR;
        S_UP_WR:   state_r <= S_FIN;
        S_RM_ROOT: state_r <= S_RM_LAST;
        S_RM_LAST: state_r <= S_RM_LOAD;
        S_RM_LOAD: state_r <= S_DN_RDL;
        S_DN_RDL:  state_r <= sts.has_left ? S_DN_RDR : S_DN_WR;
        S_DN_RDR:  state_r <= S_DN_CMP;
        S_DN_CMP:  state_r <= sts.dn_move ? S_DN_RDL : S_DN_WR;
        S_DN_WR:   state_r <= S_FIN;
        S_FIN:     state_r <= S_RES;
        S_RES:     state_r <= S_OUT;
        S_OUT:     if (out_tready) state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CHECK) else $error("accept lost");
`endif

endmodule
